FILE: rtl/sva_pkg.sv
// Shared types and constants of the story VM ALU.
// No dependencies; imported by every module under rtl.
package sva_pkg;

    localparam int WORD_W    = 16;
    localparam int KIND_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = 4;
    localparam int IN_DATA_W  = 5 * WORD_W;
    localparam int OUT_DATA_W = 24;

    localparam logic [WORD_W-1:0] SEED_FIRST_RST  = 16'h1234;
    localparam logic [WORD_W-1:0] SEED_SECOND_RST = 16'h5678;
    localparam logic [WORD_W-1:0] RND_MASK        = 16'h7FFF;
    localparam logic [WORD_W-1:0] EQ_COUNT_THREE  = 16'd3;
    localparam logic [WORD_W-1:0] EQ_COUNT_FOUR   = 16'd4;
    localparam logic [STEP_W-1:0] LAST_STEP       = 4'd15;

    localparam logic [CFG_IDX_W-1:0] REG_SEED_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_SECOND = 2'd1;

    typedef enum logic [KIND_W-1:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_MOD     = 4'd4,
        OP_RANDOM  = 4'd5,
        OP_LT      = 4'd6,
        OP_GT      = 4'd7,
        OP_BITTEST = 4'd8,
        OP_OR      = 4'd9,
        OP_NOT     = 4'd10,
        OP_AND     = 4'd11,
        OP_EQ_ANY  = 4'd12,
        OP_ZERO    = 4'd13
    } op_kind_t;

    typedef enum logic [1:0] {
        SEQ_MUL = 2'd0,
        SEQ_DIV = 2'd1,
        SEQ_MOD = 2'd2,
        SEQ_RND = 2'd3
    } seq_op_t;

    typedef struct packed {
        logic    start;
        seq_op_t op;
    } seq_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } seq_stat_t;

    typedef struct packed {
        logic                 wr;
        logic [CFG_IDX_W-1:0] index;
        logic [WORD_W-1:0]    data;
    } cfg_wr_t;

endpackage

FILE: rtl/sva_rng.sv
// Two-word shift-and-xor random generator with seed loading.
// Depends on sva_pkg.
module sva_rng import sva_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_wr_t           cfg,
    input  logic              step,
    output logic [WORD_W-1:0] step_second
);

    logic [WORD_W-1:0] first_reg, first_next;
    logic [WORD_W-1:0] second_reg, second_next;

    assign step_second = second_reg ^ {first_reg[WORD_W-2:0], second_reg[WORD_W-1]};

    always_comb begin
        first_next  = first_reg;
        second_next = second_reg;
        if (cfg.wr && cfg.index == REG_SEED_FIRST) begin
            first_next = cfg.data;
        end else if (cfg.wr && cfg.index == REG_SEED_SECOND) begin
            second_next = cfg.data;
        end else if (step) begin
            first_next  = second_reg;
            second_next = step_second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg  <= SEED_FIRST_RST;
            second_reg <= SEED_SECOND_RST;
        end else begin
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_step_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !cfg.wr |=> first_reg == $past(second_reg))
        else $error("generator step lost the second word");
`endif

endmodule

FILE: rtl/sva_seq.sv
// Bit-serial multiply and restoring divide unit (quotient, remainder, or remainder plus one), one bit per cycle.
// Depends on sva_pkg.
module sva_seq import sva_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  seq_cmd_t          cmd,
    input  logic [WORD_W-1:0] opnd_a,
    input  logic [WORD_W-1:0] opnd_b,
    output seq_stat_t         stat,
    output logic [WORD_W-1:0] result
);

    logic [WORD_W-1:0] x_reg, x_next;
    logic [WORD_W-1:0] y_reg, y_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    seq_op_t           op_reg, op_next;
    logic              negq_reg, negq_next;
    logic              negr_reg, negr_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   diff;
    logic              ge;
    logic [WORD_W-1:0] mag_a, mag_b;

    assign mag_a  = opnd_a[WORD_W-1] ? (~opnd_a + 1'b1) : opnd_a;
    assign mag_b  = opnd_b[WORD_W-1] ? (~opnd_b + 1'b1) : opnd_b;
    assign rem_sh = {rem_reg, x_reg[WORD_W-1]};
    assign diff   = rem_sh - {1'b0, y_reg};
    assign ge     = !diff[WORD_W];

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        op_next   = op_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start) begin
            op_next   = cmd.op;
            acc_next  = '0;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            negq_next = opnd_a[WORD_W-1] ^ opnd_b[WORD_W-1];
            negr_next = opnd_a[WORD_W-1];
            if (cmd.op == SEQ_DIV || cmd.op == SEQ_MOD) begin
                x_next = mag_a;
                y_next = mag_b;
            end else begin
                x_next = opnd_a;
                y_next = opnd_b;
            end
        end else if (busy_reg) begin
            if (op_reg == SEQ_MUL) begin
                acc_next = acc_reg + (y_reg[0] ? x_reg : '0);
                x_next   = {x_reg[WORD_W-2:0], 1'b0};
                y_next   = {1'b0, y_reg[WORD_W-1:1]};
            end else begin
                rem_next = ge ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
                x_next   = {x_reg[WORD_W-2:0], ge};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        op_reg   <= op_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    always_comb begin
        unique case (op_reg)
            SEQ_MUL: result = acc_reg;
            SEQ_DIV: result = negq_reg ? (~x_reg + 1'b1) : x_reg;
            SEQ_MOD: result = negr_reg ? (~rem_reg + 1'b1) : rem_reg;
            SEQ_RND: result = rem_reg + 1'b1;
            default: result = '0;
        endcase
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("serial unit finished without running");
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> !busy_reg)
        else $error("serial unit restarted while busy");
`endif

endmodule

FILE: rtl/story_vm_alu_unit.sv
// Top level of the story VM ALU: input/output beat handling, combinational ops,
// control of the serial unit. Depends on sva_pkg, sva_rng and sva_seq.
//
// One instruction beat is taken at a time. Add, sub, the logic ops and all tests
// are computed on accept and go to the hold state; mul, div, mod and random run
// through the 16 one-bit steps of the shared serial multiply/divide unit, then
// the hold state. Division by zero and random with a zero range skip the serial
// unit and go to the hold state with the error flag. A finished result waits in
// the output register while the next beat is accepted. Seed writes may be given
// at any time the block is idle; cfg_ready is always high.
module story_vm_alu_unit import sva_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // op_a, op_b, op_c, op_d, count_or_range
    input  logic [KIND_W-1:0]     s_tuser,   // kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // value, condition, error, zero fill
    output logic                  m_tuser,   // is_test
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [WORD_W-1:0] val_reg, val_next;
    logic              test_reg, test_next;
    logic              cond_reg, cond_next;
    logic              err_reg, err_next;
    logic [WORD_W-1:0] out_val_reg, out_val_next;
    logic              out_test_reg, out_test_next;
    logic              out_cond_reg, out_cond_next;
    logic              out_err_reg, out_err_next;
    logic              out_valid_reg, out_valid_next;

    op_kind_t          kind;
    logic [WORD_W-1:0] op_a, op_b, op_c, op_d, num;
    logic              accept;
    logic              serial;
    logic              rng_step;
    logic [WORD_W-1:0] imm_val;
    logic              imm_test, imm_cond, imm_err;
    logic [WORD_W-1:0] seq_a, seq_b, seq_res, rng_second;
    seq_op_t           seq_op;
    seq_cmd_t          seq_cmd;
    seq_stat_t         seq_st;
    cfg_wr_t           cfg;

    assign kind = op_kind_t'(s_tuser);
    assign op_a = s_tdata[WORD_W-1:0];
    assign op_b = s_tdata[2*WORD_W-1:WORD_W];
    assign op_c = s_tdata[3*WORD_W-1:2*WORD_W];
    assign op_d = s_tdata[4*WORD_W-1:3*WORD_W];
    assign num  = s_tdata[5*WORD_W-1:4*WORD_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg.wr    = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    always_comb begin
        imm_val  = '0;
        imm_test = 1'b0;
        imm_cond = 1'b0;
        imm_err  = 1'b0;
        serial   = 1'b0;
        seq_op   = SEQ_MUL;
        seq_a    = op_a;
        seq_b    = op_b;
        unique case (kind)
            OP_ADD: imm_val = op_a + op_b;
            OP_SUB: imm_val = op_a - op_b;
            OP_MUL: serial = 1'b1;
            OP_DIV: begin
                seq_op  = SEQ_DIV;
                serial  = (op_b != '0);
                imm_err = (op_b == '0);
            end
            OP_MOD: begin
                seq_op  = SEQ_MOD;
                serial  = (op_b != '0);
                imm_err = (op_b == '0);
            end
            OP_RANDOM: begin
                seq_op  = SEQ_RND;
                seq_a   = rng_second & RND_MASK;
                seq_b   = num;
                serial  = (num != '0);
                imm_err = (num == '0);
            end
            OP_LT: begin
                imm_test = 1'b1;
                imm_cond = $signed(op_a) < $signed(op_b);
            end
            OP_GT: begin
                imm_test = 1'b1;
                imm_cond = $signed(op_a) > $signed(op_b);
            end
            OP_BITTEST: begin
                imm_test = 1'b1;
                imm_cond = ((op_b & ~op_a) == '0);
            end
            OP_OR:  imm_val = op_a | op_b;
            OP_NOT: imm_val = ~op_a;
            OP_AND: imm_val = op_a & op_b;
            OP_EQ_ANY: begin
                imm_test = 1'b1;
                imm_cond = (op_a == op_b)
                        || (num >= EQ_COUNT_THREE && op_a == op_c)
                        || (num == EQ_COUNT_FOUR && op_a == op_d);
            end
            OP_ZERO: begin
                imm_test = 1'b1;
                imm_cond = (op_a == '0);
            end
            default: imm_val = '0;
        endcase
    end

    assign rng_step      = accept && serial && (kind == OP_RANDOM);
    assign seq_cmd.start = accept && serial;
    assign seq_cmd.op    = seq_op;

    sva_rng u_rng (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .step        (rng_step),
        .step_second (rng_second)
    );

    sva_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (seq_cmd),
        .opnd_a  (seq_a),
        .opnd_b  (seq_b),
        .stat    (seq_st),
        .result  (seq_res)
    );

    always_comb begin
        state_next     = state_reg;
        val_next       = val_reg;
        test_next      = test_reg;
        cond_next      = cond_reg;
        err_next       = err_reg;
        out_val_next   = out_val_reg;
        out_test_next  = out_test_reg;
        out_cond_next  = out_cond_reg;
        out_err_next   = out_err_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    val_next   = imm_val;
                    test_next  = imm_test;
                    cond_next  = imm_cond;
                    err_next   = imm_err;
                    state_next = serial ? ST_RUN : ST_HOLD;
                end
            end
            ST_RUN: begin
                if (seq_st.done) begin
                    val_next   = seq_res;
                    test_next  = 1'b0;
                    cond_next  = 1'b0;
                    err_next   = 1'b0;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!out_valid_reg || m_tready) begin
                    out_val_next   = val_reg;
                    out_test_next  = test_reg;
                    out_cond_next  = cond_reg;
                    out_err_next   = err_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        val_reg      <= val_next;
        test_reg     <= test_next;
        cond_reg     <= cond_next;
        err_reg      <= err_next;
        out_val_reg  <= out_val_next;
        out_test_reg <= out_test_next;
        out_cond_reg <= out_cond_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_test_reg;
    assign m_tdata  = {{(OUT_DATA_W-WORD_W-2){1'b0}}, out_err_reg, out_cond_reg, out_val_reg};

`ifndef NO_ASSERTIONS
    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_st.done |-> state_reg == ST_RUN)
        else $error("serial result arrived outside the run state");
    a_err_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_err_reg |-> out_val_reg == '0 && !out_test_reg)
        else $error("error beat carries a value");
    a_test_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_test_reg |-> out_val_reg == '0 && !out_err_reg)
        else $error("test beat carries a value or error");
    a_idle_unit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !seq_st.busy)
        else $error("serial unit busy while idle");
`endif

endmodule

FILE: tb/story_vm_alu_unit_check.sv
// Checker for story_vm_alu_unit: watches the instruction, result and seed channels,
// predicts each result and compares it field by field. Depends on sva_pkg.
`timescale 1ns / 1ps

module story_vm_alu_unit_check import sva_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // op_a, op_b, op_c, op_d, count_or_range
    input  logic [KIND_W-1:0]     s_tuser,   // kind
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // value, condition, error, zero fill
    input  logic                  m_tuser,   // is_test
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0]     cfg_data,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              is_test;
        logic              condition;
        logic              error;
        logic [5:0]        pad;
    } alu_result_t;

    logic [WORD_W-1:0] rng_first;
    logic [WORD_W-1:0] rng_second;
    alu_result_t       result_q[$];

    function automatic alu_result_t compute_alu(input logic [KIND_W-1:0] kind,
                                                input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b,
                                                input logic [WORD_W-1:0] c,
                                                input logic [WORD_W-1:0] d,
                                                input logic [WORD_W-1:0] n);
        alu_result_t       r;
        int                sa;
        int                sb;
        int                q;
        int unsigned       pick;
        logic [WORD_W-1:0] t;
        r  = '0;
        sa = $signed(a);
        sb = $signed(b);
        case (kind)
            OP_ADD: r.value = a + b;
            OP_SUB: r.value = a - b;
            OP_MUL: r.value = a * b;
            OP_DIV, OP_MOD: begin
                if (b == '0) begin
                    r.error = 1'b1;
                end else begin
                    q = (kind == OP_DIV) ? sa / sb : sa % sb;
                    r.value = q[WORD_W-1:0];
                end
            end
            OP_RANDOM: begin
                if (n == '0) begin
                    r.error = 1'b1;
                end else begin
                    t = {rng_first[WORD_W-2:0], rng_second[WORD_W-1]};
                    rng_first = rng_second;
                    rng_second = rng_second ^ t;
                    pick = ({16'd0, rng_second & RND_MASK} % {16'd0, n}) + 1;
                    r.value = pick[WORD_W-1:0];
                end
            end
            OP_LT: begin
                r.is_test = 1'b1;
                r.condition = sa < sb;
            end
            OP_GT: begin
                r.is_test = 1'b1;
                r.condition = sa > sb;
            end
            OP_BITTEST: begin
                r.is_test = 1'b1;
                r.condition = (b & ~a) == '0;
            end
            OP_OR:  r.value = a | b;
            OP_NOT: r.value = ~a;
            OP_AND: r.value = a & b;
            OP_EQ_ANY: begin
                r.is_test = 1'b1;
                r.condition = (a == b) || (n >= EQ_COUNT_THREE && a == c) ||
                              (n == EQ_COUNT_FOUR && a == d);
            end
            OP_ZERO: begin
                r.is_test = 1'b1;
                r.condition = a == '0;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin
        alu_result_t want;
        alu_result_t got;
        if (!aresetn) begin
            rng_first  = SEED_FIRST_RST;
            rng_second = SEED_SECOND_RST;
            result_q.delete();
            fail_count = 0;
            pending <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[15:0], m_tuser, m_tdata[16], m_tdata[17], m_tdata[23:18]};
                if (result_q.size() == 0) begin
                    note_failure($sformatf("result beat with nothing expected: %h", got));
                end else begin
                    want = result_q.pop_front();
                    if (got !== want)
                        note_failure($sformatf(
                            "result mismatch: value %h/%h is_test %b/%b cond %b/%b err %b/%b pad %h/%h (exp/act)",
                            want.value, got.value, want.is_test, got.is_test,
                            want.condition, got.condition, want.error, got.error,
                            want.pad, got.pad));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SEED_FIRST:  rng_first = cfg_data;
                    REG_SEED_SECOND: rng_second = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                result_q.push_back(compute_alu(s_tuser, s_tdata[15:0], s_tdata[31:16],
                                               s_tdata[47:32], s_tdata[63:48],
                                               s_tdata[79:64]));
            pending <= result_q.size();
        end
    end

endmodule

FILE: tb/story_vm_alu_unit_test.sv
// Top of the story_vm_alu_unit testbench: clock, reset, instruction and seed stimulus,
// result back-pressure and the verdict. Depends on sva_pkg, the block and its checker.
`timescale 1ns / 1ps

module story_vm_alu_unit_test;
    import sva_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 215;
    localparam int SETTLE       = 25;
    localparam int CHOKE_CYCLES = 300;

    localparam logic [KIND_W-1:0]    KIND_SPARE_LO = 4'd14;
    localparam logic [KIND_W-1:0]    KIND_SPARE_HI = 4'd15;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [WORD_W-1:0]     cfg_data;
    int                    fail_count;
    int                    pending;

    int tx_idle_pct;
    int rx_idle_pct;
    bit choke_rx;
    int cycle_count = 0;

    story_vm_alu_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    story_vm_alu_unit_check i_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("story_vm_alu_unit_test NOT OK");
            $finish;
        end
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (choke_rx) begin
                m_tready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge aclk);
                choke_rx = 1'b0;
            end else begin
                m_tready <= $urandom_range(99) >= rx_idle_pct;
            end
        end
    end

    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] a,
                           input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] c,
                           input logic [WORD_W-1:0] d, input logic [WORD_W-1:0] n);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {n, d, c, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return 16'h0001;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    task automatic send_random_op();
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] n;
        kind = KIND_W'($urandom_range(15));
        a = pick_word();
        b = pick_word();
        c = pick_word();
        d = pick_word();
        n = WORD_W'($urandom);
        if (kind == OP_EQ_ANY) begin
            if ($urandom_range(3) == 0) b = a;
            if ($urandom_range(3) == 0) c = a;
            if ($urandom_range(3) == 0) d = a;
            if ($urandom_range(3) != 0) n = WORD_W'($urandom_range(6));
        end else if (kind == OP_RANDOM) begin
            case ($urandom_range(3))
                0: n = WORD_W'($urandom_range(1, 10));
                1: n = '0;
                2: n = WORD_W'($urandom_range(16'h8000, 16'hFFFF));
                default: ;
            endcase
        end
        send_op(kind, a, b, c, d, n);
    endtask

    initial begin
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= OP_ADD;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_SEED_FIRST;
        cfg_data    <= '0;
        aresetn     <= 1'b0;
        tx_idle_pct = 26;
        rx_idle_pct = 79;
        choke_rx    = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_op(OP_ADD,     16'hFFFF, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_op(OP_SUB,     16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_op(OP_MUL,     16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        send_op(OP_DIV,     16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        send_op(OP_MOD,     16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        send_op(OP_DIV,     16'hFFF9, 16'h0002, 16'h0000, 16'h0000, 16'h0000);
        send_op(OP_MOD,     16'hFFF9, 16'h0002, 16'h0000, 16'h0000, 16'h0000);
        send_op(OP_DIV,     16'h7FFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_op(OP_MOD,     16'h1234, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_op(OP_RANDOM,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_op(OP_RANDOM,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0006);
        send_op(OP_RANDOM,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        send_op(OP_LT,      16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
        send_op(OP_GT,      16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
        send_op(OP_BITTEST, 16'hF0F0, 16'h3030, 16'h0000, 16'h0000, 16'h0000);
        send_op(OP_OR,      16'hF000, 16'h000F, 16'h0000, 16'h0000, 16'h0000);
        send_op(OP_NOT,     16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_op(OP_AND,     16'hFFFF, 16'hA5A5, 16'h0000, 16'h0000, 16'h0000);
        send_op(OP_EQ_ANY,  16'h0005, 16'h0006, 16'h0007, 16'h0005, 16'h0004);
        send_op(OP_EQ_ANY,  16'h0005, 16'h0006, 16'h0005, 16'h0007, 16'h0001);
        send_op(OP_EQ_ANY,  16'h0005, 16'h0006, 16'h0007, 16'h0005, 16'h0005);
        send_op(OP_EQ_ANY,  16'h0005, 16'h0005, 16'h0000, 16'h0000, 16'h0000);
        send_op(OP_ZERO,    16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_op(KIND_SPARE_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_op(KIND_SPARE_HI, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            repeat (SETTLE) @(posedge aclk);
            case (ph)
                1: begin
                    write_reg(REG_SEED_FIRST, 16'hFFFF);
                    write_reg(REG_SEED_SECOND, 16'hFFFF);
                end
                2: begin
                    write_reg(REG_SEED_FIRST, 16'h0000);
                    write_reg(REG_SEED_SECOND, 16'h0001);
                end
                3: begin
                    write_reg(REG_SEED_SECOND, WORD_W'($urandom));
                    write_reg(REG_SPARE_LO, WORD_W'($urandom));
                    write_reg(REG_SEED_FIRST, WORD_W'($urandom));
                    write_reg(REG_SPARE_HI, WORD_W'($urandom));
                end
                4: begin
                    write_reg(REG_SEED_FIRST, 16'h0000);
                    write_reg(REG_SEED_SECOND, 16'h0000);
                end
                5: begin
                    write_reg(REG_SEED_FIRST, WORD_W'($urandom));
                    write_reg(REG_SEED_SECOND, WORD_W'($urandom_range(16'h8000, 16'hFFFF)));
                end
                default: ;
            endcase
            cfg_valid <= 1'b0;
            tx_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 79 : 0;
            rx_idle_pct = (ph < 2) ? 79 : (ph < 4) ? 26 : 0;
            if (ph == PHASES - 1) begin
                choke_rx = 1'b1;
                repeat (30) send_random_op();
            end
            repeat (PHASE_ITEMS) begin
                send_random_op();
                if ($urandom_range(99) == 0)
                    drain();
            end
        end

        drain();
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("story_vm_alu_unit_test OK");
        else
            $display("story_vm_alu_unit_test NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/sva_pkg.sv
rtl/sva_rng.sv
rtl/sva_seq.sv
rtl/story_vm_alu_unit.sv
tb/story_vm_alu_unit_check.sv
tb/story_vm_alu_unit_test.sv
